### src/keyed_lru_result_cache_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed LRU result cache
// Short forms for the clocked, reset-qualified checks used in the design.
// ----------------------------------------------------------------------------
`ifndef KEYED_LRU_RESULT_CACHE_MACROS_SVH
`define KEYED_LRU_RESULT_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/klc_pkg.sv
// ----------------------------------------------------------------------------
// Keyed LRU result cache package
// Shared types and constants: request commands, entry layout, scan control.
// ----------------------------------------------------------------------------
package klc_pkg;

  localparam int unsigned PidW  = 32;
  localparam int unsigned AddrW = 64;
  localparam int unsigned TickW = 64;
  localparam int unsigned RefW  = 32;
  localparam int unsigned SlotW = 8;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_PROBE  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [PidW-1:0]  proc_id;
    logic [AddrW-1:0] addr;
    logic [TickW-1:0] tick;
    logic [RefW-1:0]  text_ref;
    logic [RefW-1:0]  path_ref;
  } entry_t;

  typedef struct packed {
    logic clear;    // start of a new request, drop all scan results
    logic cmp_vld;  // read data of the entry at the compare index is valid
  } scan_ctl_t;

endpackage

### src/klc_entry_ram.sv
// ----------------------------------------------------------------------------
// Entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module klc_entry_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  klc_pkg::entry_t      wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output klc_pkg::entry_t      rdata_o
);
  import klc_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/klc_scan_unit.sv
// ----------------------------------------------------------------------------
// Scan compare unit
// Compares one entry per cycle while cmp_vld is set against the request key
// and keeps the first match and the lowest-index entry with the oldest tick.
// ----------------------------------------------------------------------------
module klc_scan_unit #(
  parameter int unsigned IdxW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  klc_pkg::scan_ctl_t            ctl_i,
  input  logic [IdxW-1:0]               cmp_idx_i,
  input  klc_pkg::entry_t               entry_i,
  input  logic [klc_pkg::PidW-1:0]      key_pid_i,
  input  logic [klc_pkg::AddrW-1:0]     key_addr_i,
  output logic                          hit_o,
  output logic [IdxW-1:0]               hit_idx_o,
  output klc_pkg::entry_t               hit_entry_o,
  output logic [IdxW-1:0]               old_idx_o
);
  import klc_pkg::*;

  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  entry_t           hit_entry_q, hit_entry_d;
  logic [TickW-1:0] old_tick_q, old_tick_d;
  logic [IdxW-1:0]  old_idx_q, old_idx_d;
  logic             key_eq;
  logic             older;

  assign key_eq = (entry_i.proc_id == key_pid_i) && (entry_i.addr == key_addr_i);
  assign older  = entry_i.tick < old_tick_q;

  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_entry_d = hit_entry_q;
    old_tick_d  = old_tick_q;
    old_idx_d   = old_idx_q;
    if (ctl_i.clear) begin
      hit_d      = 1'b0;
      hit_idx_d  = '0;
      old_tick_d = '1;
      old_idx_d  = '0;
    end else if (ctl_i.cmp_vld && !hit_q) begin
      if (key_eq) begin
        hit_d       = 1'b1;
        hit_idx_d   = cmp_idx_i;
        hit_entry_d = entry_i;
      end else if (older) begin
        old_tick_d = entry_i.tick;
        old_idx_d  = cmp_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      old_tick_q <= '1;
      old_idx_q  <= '0;
    end else begin
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      old_tick_q <= old_tick_d;
      old_idx_q  <= old_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_entry_q <= hit_entry_d;
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_entry_o = hit_entry_q;
  assign old_idx_o   = old_idx_q;

endmodule

### src/keyed_lru_result_cache.sv
// ----------------------------------------------------------------------------
// Keyed LRU result cache
// Fully associative cache keyed by process id and address, with lookup,
// probe and store requests and oldest-tick replacement.
// ----------------------------------------------------------------------------
// Usage: a request enters on the s_axis channel (tuser carries the command
// and the path flag, tdata the key, tick and references) and exactly one
// result leaves on the m_axis channel (tuser carries the hit flag, tdata the
// references and the slot index). The block takes one request at a time:
// s_axis_tready is high only while the sequencer is idle.
// Each request that needs a scan walks the filled entries in ascending order,
// one entry per cycle through a single compare unit fed by the entry RAM read
// port. At most ENTRIES entries are compared, and a hit ends the scan early;
// the result then passes through the update state into the output register,
// and the sequencer returns to idle as it is registered, so the next request
// can be accepted while the result waits. A lookup or probe with a zero
// address, or an unused command, skips the scan and goes to the update state.
// Entries fill from slot 0 upward and are never freed, so a fill count
// stands for the valid bits. Reset clears the fill count and the sequencer
// at once; no clearing pass is needed. If the receiver stalls, the finished
// result waits in the output register, the next request may still be
// accepted and scanned, and its write-back waits until the output is free.
// ----------------------------------------------------------------------------
`include "keyed_lru_result_cache_macros.svh"

module keyed_lru_result_cache #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] proc_id, [95:32] lookup_addr, [159:96] now_tick,
  // [191:160] text_ref_in, [223:192] path_ref_in
  input  logic [223:0] s_axis_tdata,
  // [1:0] cmd, [2] path_given
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] text_ref_out, [63:32] path_ref_out, [71:64] slot_index
  output logic [71:0]  m_axis_tdata,
  // [0] hit
  output logic         m_axis_tuser
);
  import klc_pkg::*;

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned WideW = (IdxW > SlotW) ? IdxW : SlotW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e           state_q;
  logic [1:0]       cmd_q;
  logic             path_given_q;
  logic [PidW-1:0]  pid_q;
  logic [AddrW-1:0] addr_q;
  logic [TickW-1:0] now_q;
  logic [RefW-1:0]  text_q;
  logic [RefW-1:0]  path_q;
  logic [CntW-1:0]  fill_q;
  logic [CntW-1:0]  rd_idx_q;
  logic             cmp_vld_q;
  logic [IdxW-1:0]  cmp_idx_q;
  logic             out_vld_q;
  logic             out_hit_q;
  logic [RefW-1:0]  out_text_q;
  logic [RefW-1:0]  out_path_q;
  logic [SlotW-1:0] out_slot_q;

  logic             in_fire;
  logic             early;
  logic             rd_more;
  logic             rd_en;
  logic             scan_done;
  logic             out_free;
  logic             full;
  logic             is_lookup;
  logic             is_store;
  logic             is_probe;
  logic             we;
  logic [IdxW-1:0]  waddr;
  entry_t           wdata;
  entry_t           rd_entry;
  logic             res_hit;
  logic [RefW-1:0]  res_text;
  logic [RefW-1:0]  res_path;
  logic [IdxW-1:0]  res_idx;
  logic [WideW-1:0] res_idx_wide;
  scan_ctl_t        scan_ctl;
  logic             scan_hit;
  logic [IdxW-1:0]  scan_hit_idx;
  entry_t           scan_hit_entry;
  logic [IdxW-1:0]  scan_old_idx;
  logic [1:0]       in_cmd;
  logic [AddrW-1:0] in_addr;

  assign in_cmd  = s_axis_tuser[1:0];
  assign in_addr = s_axis_tdata[95:32];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Zero-address lookups and probes, and unused commands, need no scan.
  assign early = (((in_cmd == CMD_LOOKUP) || (in_cmd == CMD_PROBE)) && (in_addr == '0))
              || !((in_cmd == CMD_LOOKUP) || (in_cmd == CMD_STORE) || (in_cmd == CMD_PROBE));

  assign is_lookup = (cmd_q == CMD_LOOKUP);
  assign is_store  = (cmd_q == CMD_STORE);
  assign is_probe  = (cmd_q == CMD_PROBE);

  // Only the filled prefix of the RAM holds valid entries.
  assign rd_more   = rd_idx_q < fill_q;
  assign rd_en     = (state_q == ST_SCAN) && rd_more && !scan_hit;
  assign scan_done = scan_hit || (!rd_more && !cmp_vld_q);
  assign out_free  = !out_vld_q || m_axis_tready;
  assign full      = (fill_q == CntW'(ENTRIES));

  assign scan_ctl.clear   = in_fire;
  assign scan_ctl.cmp_vld = cmp_vld_q;

  klc_entry_ram #(
    .Depth (ENTRIES),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  klc_scan_unit #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .cmp_idx_i   (cmp_idx_q),
    .entry_i     (rd_entry),
    .key_pid_i   (pid_q),
    .key_addr_i  (addr_q),
    .hit_o       (scan_hit),
    .hit_idx_o   (scan_hit_idx),
    .hit_entry_o (scan_hit_entry),
    .old_idx_o   (scan_old_idx)
  );

  // Write-back and result of the finished scan.
  always_comb begin
    wdata    = scan_hit_entry;
    waddr    = scan_hit_idx;
    res_hit  = 1'b0;
    res_text = '0;
    res_path = '0;
    res_idx  = '0;
    we       = 1'b0;
    if (is_lookup && scan_hit) begin
      wdata.tick = now_q;
      we         = 1'b1;
      res_hit    = 1'b1;
      res_text   = scan_hit_entry.text_ref;
      res_path   = scan_hit_entry.path_ref;
      res_idx    = scan_hit_idx;
    end else if (is_probe && scan_hit) begin
      res_hit = 1'b1;
      res_idx = scan_hit_idx;
    end else if (is_store && scan_hit) begin
      wdata.tick     = now_q;
      wdata.text_ref = text_q;
      if (path_given_q) begin
        wdata.path_ref = path_q;
      end
      we      = 1'b1;
      res_hit = 1'b1;
      res_idx = scan_hit_idx;
    end else if (is_store) begin
      // No match: fill the first free slot, or replace the oldest entry.
      wdata.proc_id  = pid_q;
      wdata.addr     = addr_q;
      wdata.tick     = now_q;
      wdata.text_ref = text_q;
      wdata.path_ref = path_given_q ? path_q : '0;
      waddr          = full ? scan_old_idx : fill_q[IdxW-1:0];
      we             = 1'b1;
      res_idx        = waddr;
    end
    we = we && (state_q == ST_UPDATE) && out_free;
  end

  assign res_idx_wide = WideW'(res_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      // A waiting result stays until taken; a finished request loads a new one.
      out_vld_q <= (out_vld_q && !m_axis_tready) || ((state_q == ST_UPDATE) && out_free);
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            rd_idx_q <= '0;
            state_q  <= early ? ST_UPDATE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end
          if (scan_done) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            if (is_store && !scan_hit && !full) begin
              fill_q <= fill_q + CntW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q[IdxW-1:0];
    if (in_fire) begin
      cmd_q        <= in_cmd;
      path_given_q <= s_axis_tuser[2];
      pid_q        <= s_axis_tdata[31:0];
      addr_q       <= in_addr;
      now_q        <= s_axis_tdata[159:96];
      text_q       <= s_axis_tdata[191:160];
      path_q       <= s_axis_tdata[223:192];
    end
    if ((state_q == ST_UPDATE) && out_free) begin
      out_hit_q  <= res_hit;
      out_text_q <= res_text;
      out_path_q <= res_path;
      out_slot_q <= res_idx_wide[SlotW-1:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {out_slot_q, out_path_q, out_text_q};

  `KLC_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CntW'(ENTRIES),
                  "fill count exceeds the number of entries")
  `KLC_ASSERT_NOW(a_hit_in_fill, clk_i, rst_ni, (state_q != ST_IDLE) && scan_hit,
                  {1'b0, scan_hit_idx} < {1'b0, fill_q}, "hit reported outside filled entries")
  `KLC_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_fire, !s_axis_tready,
                   "request accepted while another is in progress")
  `KLC_ASSERT_NEXT(a_hold_update, clk_i, rst_ni,
                   (state_q == ST_UPDATE) && out_vld_q && !m_axis_tready,
                   state_q == ST_UPDATE, "result overwritten while the output is stalled")

endmodule

### sim/keyed_lru_result_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed LRU result cache testbench
// Sends lookup, probe, store and unused-command requests through the stream
// ports. A shadow copy of the cache predicts every result, and each returned
// result is checked field by field. Both channels stall at random.
// ----------------------------------------------------------------------------
module keyed_lru_result_cache_tb;
  import klc_pkg::*;

  localparam int unsigned ENTRIES = 256;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1730;
  // The last requests run with both channels always ready.
  localparam int QUIET_TAIL = 200;
  localparam int REPORT_LIMIT = 100;
  localparam logic [31:0] ALL32 = '1;
  localparam logic [63:0] ALL64 = '1;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] pid;
    logic [63:0] addr;
    logic [63:0] tick;
    logic [31:0] text_ref;
    logic [31:0] path_ref;
    logic        path_en;
    bit          drain;     // hold this request until every result is back
  } cache_request_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] text_ref;
    logic [31:0] path_ref;
    logic [7:0]  slot;
  } cache_result_t;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  // [31:0] proc_id, [95:32] lookup_addr, [159:96] now_tick,
  // [191:160] text_ref_in, [223:192] path_ref_in
  logic [223:0]  s_axis_tdata = '0;
  // [1:0] cmd, [2] path_given
  logic [2:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // [31:0] text_ref_out, [63:32] path_ref_out, [71:64] slot_index
  logic [71:0]   m_axis_tdata;
  // [0] hit
  logic          m_axis_tuser;

  // Shadow copy of the cache contents.
  bit            shadow_valid [ENTRIES];
  logic [31:0]   shadow_pid   [ENTRIES];
  logic [63:0]   shadow_addr  [ENTRIES];
  logic [63:0]   shadow_tick  [ENTRIES];
  logic [31:0]   shadow_text  [ENTRIES];
  logic [31:0]   shadow_path  [ENTRIES];

  cache_request_t pending_requests [$];
  cache_result_t  expected_results [$];

  int total_requests = 0;
  int accepted_count = 0;
  int sent_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int count_lookups = 0;
  int count_stores = 0;
  int count_probes = 0;
  int count_unused = 0;
  int count_hits = 0;
  int count_evictions = 0;

  keyed_lru_result_cache #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Applies one request to the shadow cache and returns the result it should
  // produce. Both the search and the victim choice walk the slots upward.
  function automatic cache_result_t predict_cache_access(
    input logic [1:0]  op,
    input logic [31:0] pid,
    input logic [63:0] addr,
    input logic [63:0] now,
    input logic [31:0] text_ref,
    input logic [31:0] path_ref,
    input logic        path_en
  );
    cache_result_t res;
    int i;
    int found;
    int victim;
    logic [63:0] oldest;
    bit done;
    res = '0;
    found = -1;
    victim = 0;
    oldest = '1;
    done = 1'b0;
    case (op)
      CMD_LOOKUP, CMD_PROBE: begin
        if (op == CMD_LOOKUP) count_lookups++;
        else count_probes++;
        // A zero address never hits, even when a store wrote it.
        if (addr != '0) begin
          for (i = 0; i < ENTRIES && found < 0; i++) begin
            if (shadow_valid[i] && shadow_pid[i] == pid && shadow_addr[i] == addr) found = i;
          end
        end
        if (found >= 0) begin
          count_hits++;
          res.hit = 1'b1;
          res.slot = found[7:0];
          if (op == CMD_LOOKUP) begin
            res.text_ref = shadow_text[found];
            res.path_ref = shadow_path[found];
            shadow_tick[found] = now;
          end
        end
      end
      CMD_STORE: begin
        count_stores++;
        // Stop at a key match or at the first empty slot; otherwise track
        // the first slot holding the smallest tick.
        for (i = 0; i < ENTRIES && !done; i++) begin
          if (shadow_valid[i] && shadow_pid[i] == pid && shadow_addr[i] == addr) begin
            found = i;
            done = 1'b1;
          end else if (!shadow_valid[i]) begin
            victim = i;
            done = 1'b1;
          end else if (shadow_tick[i] < oldest) begin
            oldest = shadow_tick[i];
            victim = i;
          end
        end
        if (found >= 0) begin
          count_hits++;
          res.hit = 1'b1;
          res.slot = found[7:0];
          shadow_tick[found] = now;
          shadow_text[found] = text_ref;
          if (path_en) shadow_path[found] = path_ref;
        end else begin
          if (shadow_valid[victim]) count_evictions++;
          res.slot = victim[7:0];
          shadow_valid[victim] = 1'b1;
          shadow_pid[victim] = pid;
          shadow_addr[victim] = addr;
          shadow_tick[victim] = now;
          shadow_text[victim] = text_ref;
          shadow_path[victim] = path_en ? path_ref : '0;
        end
      end
      default: count_unused++;
    endcase
    return res;
  endfunction

  function automatic void add_request(
    input logic [1:0]  op,
    input logic [31:0] pid,
    input logic [63:0] addr,
    input logic [63:0] tick,
    input logic [31:0] text_ref,
    input logic [31:0] path_ref,
    input logic        path_en,
    input bit          drain
  );
    cache_request_t req;
    req.op = op;
    req.pid = pid;
    req.addr = addr;
    req.tick = tick;
    req.text_ref = text_ref;
    req.path_ref = path_ref;
    req.path_en = path_en;
    req.drain = drain;
    pending_requests.push_back(req);
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Random stalls pause in stretches of 64 requests and stop near the end.
  function automatic bit idling_allowed();
    return (accepted_count + QUIET_TAIL < total_requests) && ((accepted_count / 64) % 3 != 0);
  endfunction

  // Request driver: presents the queued requests on the falling edge.
  always @(negedge clk_i) begin
    cache_request_t req;
    if (rst_ni) begin
      if (!(s_axis_tvalid && accepted_count != sent_count)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].drain && expected_results.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          s_axis_tdata <= {req.path_ref, req.text_ref, req.tick, req.addr, req.pid};
          s_axis_tuser <= {req.path_en, req.op};
          s_axis_tvalid <= 1'b1;
          sent_count++;
        end
      end
    end
  end

  // Result receiver: random bursts of back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: checks results first, then predicts the request taken this edge.
  always @(posedge clk_i) begin
    cache_result_t seen;
    cache_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.hit = m_axis_tuser;
        seen.text_ref = m_axis_tdata[31:0];
        seen.path_ref = m_axis_tdata[63:32];
        seen.slot = m_axis_tdata[71:64];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding, expected none, actual 0x%0h",
                     $time, seen);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(seen.hit));
          check_field("text_ref_out", 64'(want.text_ref), 64'(seen.text_ref));
          check_field("path_ref_out", 64'(want.path_ref), 64'(seen.path_ref));
          check_field("slot_index", 64'(want.slot), 64'(seen.slot));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_cache_access(
          s_axis_tuser[1:0], s_axis_tdata[31:0], s_axis_tdata[95:32], s_axis_tdata[159:96],
          s_axis_tdata[191:160], s_axis_tdata[223:192], s_axis_tuser[2]));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  initial begin
    int n;
    int r;
    int span;
    int tick_mode;
    bit fill_phase;
    bit reuse;
    logic [1:0]  op;
    logic [31:0] pid;
    logic [63:0] addr;
    logic [63:0] tick;
    logic [63:0] tick_counter;
    logic [95:0] key;
    logic [95:0] key_pool [$];

    // Directed requests: empty-cache misses, field extremes, zero address,
    // refresh with and without a path, near-miss keys, unused command.
    add_request(CMD_LOOKUP, 32'h1, 64'h10, 64'd1, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_PROBE, 32'h1, 64'h10, 64'd1, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_UNUSED, ALL32, ALL64, ALL64, ALL32, ALL32, 1'b1, 1'b0);
    add_request(CMD_STORE, 32'h0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_LOOKUP, 32'h0, 64'h0, 64'd7, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_PROBE, 32'h0, 64'h0, 64'd7, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_STORE, ALL32, ALL64, ALL64, ALL32, ALL32, 1'b1, 1'b0);
    add_request(CMD_LOOKUP, ALL32, ALL64, 64'd5, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_PROBE, ALL32, ALL64, 64'd6, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_STORE, ALL32, ALL64, ALL64, 32'h1234_5678, 32'hdead_beef, 1'b0, 1'b0);
    add_request(CMD_LOOKUP, ALL32, ALL64, 64'd9, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_STORE, 32'h42, 64'h8000_0000_0000_0000, 64'd3, 32'hcafe, 32'hffff_0000,
                1'b0, 1'b0);
    add_request(CMD_LOOKUP, 32'h42, 64'h8000_0000_0000_0000, 64'd4, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_STORE, 32'h42, 64'h1, 64'd3, 32'h5555_aaaa, 32'haaaa_5555, 1'b1, 1'b0);
    add_request(CMD_LOOKUP, 32'h43, 64'h1, 64'd8, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_LOOKUP, 32'h42, 64'h2, 64'd8, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_STORE, 32'h0, 64'h0, ALL64, 32'h7, 32'h9, 1'b1, 1'b1);
    add_request(CMD_UNUSED, 32'h0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_PROBE, 32'h42, 64'h1, 64'd10, 32'h0, 32'h0, 1'b0, 1'b0);
    add_request(CMD_LOOKUP, 32'h42, 64'h1, 64'h0, 32'h0, 32'h0, 1'b0, 1'b0);

    // Random requests. The opening stretch is store-heavy with new keys so
    // the cache fills and evictions start; afterwards recent keys are reused
    // so lookups and stores hit as well as miss. Tick style is redrawn every
    // hundred requests: rising, a tiny range that forces eviction ties, or
    // fully random.
    tick_mode = 0;
    tick_counter = 64'd100;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) tick_mode = $urandom_range(0, 2);
      fill_phase = (n < 330);
      r = $urandom_range(0, 99);
      if (r < (fill_phase ? 75 : 40)) op = CMD_STORE;
      else if (r < (fill_phase ? 88 : 72)) op = CMD_LOOKUP;
      else if (r < 96) op = CMD_PROBE;
      else op = CMD_UNUSED;

      reuse = (key_pool.size() != 0) &&
              ($urandom_range(0, 9) < ((op == CMD_STORE) ? (fill_phase ? 1 : 5) : 8));
      if (reuse) begin
        span = (key_pool.size() < 300) ? key_pool.size() : 300;
        key = key_pool[key_pool.size() - 1 - $urandom_range(0, span - 1)];
      end else begin
        // A few small process ids make same-address, other-process keys.
        if ($urandom_range(0, 3) == 0) pid = $urandom;
        else pid = $urandom_range(0, 3);
        case ($urandom_range(0, 15))
          0: addr = '0;
          1: addr = '1;
          2: addr = 64'($urandom_range(1, 7));
          default: addr = {$urandom, $urandom};
        endcase
        key = {pid, addr};
        if (op == CMD_STORE) begin
          key_pool.push_back(key);
          if (key_pool.size() > 512) void'(key_pool.pop_front());
        end
      end

      case (tick_mode)
        0: begin
          tick_counter = tick_counter + 64'($urandom_range(1, 5));
          tick = tick_counter;
        end
        1: tick = 64'($urandom_range(0, 3));
        default: tick = {$urandom, $urandom};
      endcase

      add_request(op, key[95:64], key[63:0], tick, $urandom, $urandom,
                  1'($urandom_range(0, 1)), (n == 600 || n == 1200));
    end
    total_requests = pending_requests.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count != total_requests) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // A full scan of the cache is the longest a stray result could lag.
    repeat (ENTRIES + 40) @(posedge clk_i);

    $display("Covered %0d requests: %0d lookups, %0d stores, %0d probes, %0d unused commands.",
             total_requests, count_lookups, count_stores, count_probes, count_unused);
    $display("The cache saw %0d hits and %0d evictions; %0d mismatching fields.",
             count_hits, count_evictions, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run (full scans on every
  // request plus the longest gaps and stalls).
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### keyed_lru_result_cache.f
+incdir+src
src/klc_pkg.sv
src/klc_entry_ram.sv
src/klc_scan_unit.sv
src/keyed_lru_result_cache.sv
sim/keyed_lru_result_cache_tb.sv
